// ===== src/pcs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcs_pkg
// Types and codes shared by the priority counting semaphore files.
// ----------------------------------------------------------------------------
`default_nettype none

package pcs_pkg;

    localparam int COUNT_W = 16;
    localparam int ID_W    = 8;
    localparam int TIME_W  = 16;
    localparam int SCORE_W = TIME_W + 1;

    typedef enum logic [1:0] {
        OP_URGENT_ACQ = 2'd0,
        OP_NORMAL_ACQ = 2'd1,
        OP_RELEASE    = 2'd2,
        OP_UNUSED     = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_ACQUIRED  = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_HANDED    = 3'd2,
        ST_RAISED    = 3'd3,
        ST_FULL      = 3'd4,
        ST_SATURATED = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_UWALK,
        S_UPLACE,
        S_UPOP,
        S_NPOP,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ID_W-1:0]   requester_id;
        logic [TIME_W-1:0] arrival_tick;
        logic [TIME_W-1:0] slack_time;
    } t_in_word;

    typedef struct packed {
        logic [2:0]      status;
        logic            woken_valid;
        logic [ID_W-1:0] woken_id;
        logic            woken_was_urgent;
    } t_out_word;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [ID_W-1:0]    id;
    } t_u_entry;

endpackage

`default_nettype wire

// ===== src/pcs_ram.sv =====
// ----------------------------------------------------------------------------
// pcs_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/priority_counting_semaphore.sv =====
// ----------------------------------------------------------------------------
// priority_counting_semaphore
// Counting semaphore with an ordered urgent wait queue and a fifo normal queue.
// ----------------------------------------------------------------------------
// An acquire takes the count when it is nonzero; otherwise an urgent acquire is
// queued by arrival_tick + slack_time (lower first, ties in arrival order) and a
// normal acquire is queued in order. A release hands the grant to the urgent
// head, else the normal head, else raises the count (saturating at 65535).
// Every word except opcode 3 gives one result word. The result word is
// registered through the exec and result states, with a pop state between them
// for a release that hands off; an urgent acquire that queues behind occupied
// entries walks from the tail and shifts each queued urgent entry with a larger
// score one place back, one per cycle, through the one read port and one write
// port of the urgent RAM, then writes the new entry. The result word waits while
// the output register still holds an unaccepted word, and the next command word
// can be accepted in the cycle after the result is registered. Writing
// i_cfg_wdata reloads the count and empties both queues by clearing their
// pointers and occupancy; no clearing pass is needed.
`default_nettype none

module priority_counting_semaphore
    import pcs_pkg::*;
#(
    parameter int URGENT_QUEUE_DEPTH = 16,
    parameter int NORMAL_QUEUE_DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_word           i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_word               o_out_word,
    input  wire logic               i_cfg_we,
    input  wire logic [COUNT_W-1:0] i_cfg_wdata
);

    localparam int UAW = (URGENT_QUEUE_DEPTH > 1) ? $clog2(URGENT_QUEUE_DEPTH) : 1;
    localparam int NAW = (NORMAL_QUEUE_DEPTH > 1) ? $clog2(NORMAL_QUEUE_DEPTH) : 1;
    localparam int UOW = $clog2(URGENT_QUEUE_DEPTH + 1);
    localparam int NOW = $clog2(NORMAL_QUEUE_DEPTH + 1);
    localparam int UEW = $bits(t_u_entry);

    localparam logic [UAW-1:0] U_LAST = UAW'(URGENT_QUEUE_DEPTH - 1);
    localparam logic [NAW-1:0] N_LAST = NAW'(NORMAL_QUEUE_DEPTH - 1);
    localparam logic [UOW-1:0] U_FULL = UOW'(URGENT_QUEUE_DEPTH);
    localparam logic [NOW-1:0] N_FULL = NOW'(NORMAL_QUEUE_DEPTH);

    function automatic logic [UAW-1:0] f_u_prev(input logic [UAW-1:0] p);
        return (p == '0) ? U_LAST : p - 1'b1;
    endfunction

    function automatic logic [UAW-1:0] f_u_next(input logic [UAW-1:0] p);
        return (p == U_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [NAW-1:0] f_n_next(input logic [NAW-1:0] p);
        return (p == N_LAST) ? '0 : p + 1'b1;
    endfunction

    t_state             r_state, n_state;
    t_in_word           r_in, n_in;
    logic [SCORE_W-1:0] r_score, n_score;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [UAW-1:0]     r_u_head, n_u_head, r_u_tail, n_u_tail, r_cur, n_cur;
    logic [UOW-1:0]     r_u_occ, n_u_occ, r_left, n_left;
    logic [NAW-1:0]     r_n_head, n_n_head, r_n_tail, n_n_tail;
    logic [NOW-1:0]     r_n_occ, n_n_occ;
    t_out_word          r_res, n_res;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out_word, n_out_word;

    logic           u_we, u_re;
    logic [UAW-1:0] u_waddr, u_raddr;
    t_u_entry       u_wdata, u_rdata;
    logic [UEW-1:0] u_rbits;
    logic           q_we, q_re;
    logic [NAW-1:0] q_waddr, q_raddr;
    logic [ID_W-1:0] q_wdata, q_rdata;

    assign u_rdata = t_u_entry'(u_rbits);

    pcs_ram #(.WIDTH(UEW), .DEPTH(URGENT_QUEUE_DEPTH), .AW(UAW)) u_urgent_ram (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_waddr),
        .i_wdata (UEW'(u_wdata)),
        .i_re    (u_re),
        .i_raddr (u_raddr),
        .o_rdata (u_rbits)
    );

    pcs_ram #(.WIDTH(ID_W), .DEPTH(NORMAL_QUEUE_DEPTH), .AW(NAW)) u_normal_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_re    (q_re),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= COUNT_W'(1);
            r_u_head    <= '0;
            r_u_tail    <= '0;
            r_u_occ     <= '0;
            r_n_head    <= '0;
            r_n_tail    <= '0;
            r_n_occ     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_u_head    <= n_u_head;
            r_u_tail    <= n_u_tail;
            r_u_occ     <= n_u_occ;
            r_n_head    <= n_n_head;
            r_n_tail    <= n_n_tail;
            r_n_occ     <= n_n_occ;
            r_out_valid <= n_out_valid;
        end
        r_in       <= n_in;
        r_score    <= n_score;
        r_cur      <= n_cur;
        r_left     <= n_left;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_score     = r_score;
        n_count     = r_count;
        n_u_head    = r_u_head;
        n_u_tail    = r_u_tail;
        n_u_occ     = r_u_occ;
        n_cur       = r_cur;
        n_left      = r_left;
        n_n_head    = r_n_head;
        n_n_tail    = r_n_tail;
        n_n_occ     = r_n_occ;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;

        u_we    = 1'b0;
        u_waddr = r_cur;
        u_wdata = '{score: r_score, id: r_in.requester_id};
        u_re    = 1'b0;
        u_raddr = f_u_prev(r_cur);
        q_we    = 1'b0;
        q_waddr = r_n_tail;
        q_wdata = r_in.requester_id;
        q_re    = 1'b0;
        q_raddr = r_n_head;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_word;
                    n_score = SCORE_W'(i_in_word.arrival_tick)
                            + SCORE_W'(i_in_word.slack_time);
                    if (i_in_word.opcode != OP_UNUSED) begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                n_res   = '0;
                n_state = S_RESULT;
                if (r_in.opcode == OP_RELEASE) begin
                    if (r_u_occ != '0) begin
                        u_re     = 1'b1;
                        u_raddr  = r_u_head;
                        n_u_head = f_u_next(r_u_head);
                        n_u_occ  = r_u_occ - 1'b1;
                        n_state  = S_UPOP;
                    end else if (r_n_occ != '0) begin
                        q_re     = 1'b1;
                        n_n_head = f_n_next(r_n_head);
                        n_n_occ  = r_n_occ - 1'b1;
                        n_state  = S_NPOP;
                    end else if (r_count == '1) begin
                        n_res.status = ST_SATURATED;
                    end else begin
                        n_count      = r_count + 1'b1;
                        n_res.status = ST_RAISED;
                    end
                end else if (r_count != '0) begin
                    n_count      = r_count - 1'b1;
                    n_res.status = ST_ACQUIRED;
                end else if (r_in.opcode == OP_URGENT_ACQ) begin
                    if (r_u_occ == U_FULL) begin
                        n_res.status = ST_FULL;
                    end else begin
                        n_res.status = ST_QUEUED;
                        n_u_tail     = f_u_next(r_u_tail);
                        n_u_occ      = r_u_occ + 1'b1;
                        if (r_u_occ == '0) begin
                            u_we    = 1'b1;
                            u_waddr = r_u_tail;
                        end else begin
                            u_re    = 1'b1;
                            u_raddr = f_u_prev(r_u_tail);
                            n_cur   = r_u_tail;
                            n_left  = r_u_occ;
                            n_state = S_UWALK;
                        end
                    end
                end else begin
                    if (r_n_occ == N_FULL) begin
                        n_res.status = ST_FULL;
                    end else begin
                        q_we         = 1'b1;
                        n_n_tail     = f_n_next(r_n_tail);
                        n_n_occ      = r_n_occ + 1'b1;
                        n_res.status = ST_QUEUED;
                    end
                end
            end
            S_UWALK: begin
                if (u_rdata.score > r_score) begin
                    u_we    = 1'b1;
                    u_wdata = u_rdata;
                    n_cur   = f_u_prev(r_cur);
                    n_left  = r_left - 1'b1;
                    if (r_left == UOW'(1)) begin
                        n_state = S_UPLACE;
                    end else begin
                        u_re    = 1'b1;
                        u_raddr = f_u_prev(f_u_prev(r_cur));
                    end
                end else begin
                    u_we    = 1'b1;
                    n_state = S_RESULT;
                end
            end
            S_UPLACE: begin
                u_we    = 1'b1;
                n_state = S_RESULT;
            end
            S_UPOP: begin
                n_res.woken_valid      = 1'b1;
                n_res.woken_id         = u_rdata.id;
                n_res.woken_was_urgent = 1'b1;
                n_res.status           = ST_HANDED;
                n_state                = S_RESULT;
            end
            S_NPOP: begin
                n_res.woken_valid = 1'b1;
                n_res.woken_id    = q_rdata;
                n_res.status      = ST_HANDED;
                n_state           = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // reload count and empty both queues
        if (i_cfg_we) begin
            n_count  = i_cfg_wdata;
            n_u_head = '0;
            n_u_tail = '0;
            n_u_occ  = '0;
            n_n_head = '0;
            n_n_tail = '0;
            n_n_occ  = '0;
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the priority counting semaphore.
// ----------------------------------------------------------------------------
// A scoreboard tracks the count, the ordered urgent queue and the fifo normal
// queue, predicts one result word per accepted command word but the unused
// opcode, and checks the result words in order. A short directed run covers
// ordering ties, both queues, the unused opcode and saturation. Random segments
// then mix acquire and release pressure, with reloads of the count between
// segments and random stalls on both handshakes.
// ----------------------------------------------------------------------------

module tb_top;
    import pcs_pkg::*;

    localparam int URG_DEPTH     = 16;
    localparam int NRM_DEPTH     = 16;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int SEG_WORDS     = 40;
    localparam int PHASE_SEGS    = 13;
    localparam int MAX_PRINTS    = 40;

    class sem_scoreboard;
        int unsigned   urgent_depth;
        int unsigned   normal_depth;
        bit [15:0]     count;
        t_u_entry      urgent_q[$];
        bit [ID_W-1:0] normal_q[$];
        t_out_word     expected_q[$];
        int            errors;

        function new(int unsigned u_depth, int unsigned n_depth);
            urgent_depth = u_depth;
            normal_depth = n_depth;
            errors = 0;
        endfunction

        function void reload(bit [15:0] value);
            count = value;
            urgent_q.delete();
            normal_q.delete();
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_word(t_in_word w);
            t_out_word r;
            t_u_entry  e;
            int        pos;
            r = '0;
            case (w.opcode)
                OP_URGENT_ACQ, OP_NORMAL_ACQ: begin
                    if (count != 0) begin
                        count--;
                        r.status = ST_ACQUIRED;
                    end else if (w.opcode == OP_URGENT_ACQ) begin
                        if (urgent_q.size() >= urgent_depth) begin
                            r.status = ST_FULL;
                        end else begin
                            e.score = {1'b0, w.arrival_tick} + {1'b0, w.slack_time};
                            e.id = w.requester_id;
                            pos = 0;
                            while (pos < urgent_q.size() && urgent_q[pos].score <= e.score)
                                pos++;
                            urgent_q.insert(pos, e);
                            r.status = ST_QUEUED;
                        end
                    end else if (normal_q.size() >= normal_depth) begin
                        r.status = ST_FULL;
                    end else begin
                        normal_q.push_back(w.requester_id);
                        r.status = ST_QUEUED;
                    end
                end
                OP_RELEASE: begin
                    if (urgent_q.size() != 0) begin
                        e = urgent_q.pop_front();
                        r.status = ST_HANDED;
                        r.woken_valid = 1'b1;
                        r.woken_id = e.id;
                        r.woken_was_urgent = 1'b1;
                    end else if (normal_q.size() != 0) begin
                        r.status = ST_HANDED;
                        r.woken_valid = 1'b1;
                        r.woken_id = normal_q.pop_front();
                    end else if (count == 16'hFFFF) begin
                        r.status = ST_SATURATED;
                    end else begin
                        count++;
                        r.status = ST_RAISED;
                    end
                end
                default: return;
            endcase
            expected_q.push_back(r);
        endfunction

        task report(string what, int got, int want);
            if (errors < MAX_PRINTS)
                $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_word(t_out_word got);
            t_out_word want;
            if (expected_q.size() == 0) begin
                report("unexpected word", int'(got), 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report("status", int'(got.status), int'(want.status));
            if (got.woken_valid !== want.woken_valid)
                report("woken_valid", int'(got.woken_valid), int'(want.woken_valid));
            if (got.woken_id !== want.woken_id)
                report("woken_id", int'(got.woken_id), int'(want.woken_id));
            if (got.woken_was_urgent !== want.woken_was_urgent)
                report("woken_was_urgent", int'(got.woken_was_urgent),
                       int'(want.woken_was_urgent));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in_word           i_in_word;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out_word          o_out_word;
    logic               i_cfg_we;
    logic [COUNT_W-1:0] i_cfg_wdata;

    sem_scoreboard sb;
    int            tx_idle;
    int            rx_idle;
    int            hold_asked;
    int            hold_done;

    priority_counting_semaphore #(
        .URGENT_QUEUE_DEPTH(URG_DEPTH),
        .NORMAL_QUEUE_DEPTH(NRM_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stalls plus long hold-offs on request
    initial begin
        i_out_ready = 1'b0;
        hold_done = 0;
        forever begin
            @(negedge i_clk);
            if (hold_done != hold_asked) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = hold_asked;
            end
            i_out_ready = ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_word(o_out_word);
    end

    always @(posedge i_clk) begin : watchdog
        int stalled;
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stalled = 0;
        else
            stalled++;
        if (stalled >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_in_word make_word(logic [1:0] op, logic [ID_W-1:0] id,
                                           logic [TIME_W-1:0] arr,
                                           logic [TIME_W-1:0] slack);
        t_in_word w;
        w.opcode = op;
        w.requester_id = id;
        w.arrival_tick = arr;
        w.slack_time = slack;
        return w;
    endfunction

    function automatic t_in_word random_word(int mode);
        t_in_word w;
        int       r;
        int       urg_lim;
        int       nrm_lim;
        r = $urandom_range(99);
        case (mode)
            0:       begin urg_lim = 45; nrm_lim = 83; end  // acquire heavy
            1:       begin urg_lim = 20; nrm_lim = 35; end  // release heavy
            2:       begin urg_lim = 30; nrm_lim = 50; end  // balanced
            default: begin urg_lim = 73; nrm_lim = 90; end  // urgent flood
        endcase
        w.requester_id = ID_W'($urandom_range(255));
        // small times make equal scores common
        if ($urandom_range(1) == 1) begin
            w.arrival_tick = TIME_W'($urandom_range(65535));
            w.slack_time = TIME_W'($urandom_range(65535));
        end else begin
            w.arrival_tick = TIME_W'($urandom_range(3));
            w.slack_time = TIME_W'($urandom_range(3));
        end
        if (r < 3)
            w.opcode = OP_UNUSED;
        else if (r < urg_lim)
            w.opcode = OP_URGENT_ACQ;
        else if (r < nrm_lim)
            w.opcode = OP_NORMAL_ACQ;
        else
            w.opcode = OP_RELEASE;
        return w;
    endfunction

    // called and returns at a falling edge
    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < tx_idle) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word = w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_word(w);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_count(logic [COUNT_W-1:0] value);
        i_cfg_we = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.reload(value);
    endtask

    function automatic logic [COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(7);
        if (r < 4)
            return '0;
        else if (r < 6)
            return COUNT_W'($urandom_range(1, 4));
        else if (r == 6)
            return '1;
        else
            return COUNT_W'($urandom_range(65535));
    endfunction

    task automatic run_phase(int tx, int rx, bit squeeze);
        tx_idle = tx;
        rx_idle = rx;
        drain();
        write_count('0);
        for (int seg = 0; seg < PHASE_SEGS; seg++) begin
            if (seg != 0 && $urandom_range(3) == 0) begin
                drain();
                write_count(pick_count());
            end
            if (squeeze && (seg == 2 || seg == 9))
                hold_asked++;
            repeat (SEG_WORDS) send_word(random_word($urandom_range(3)));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        tx_idle = 13;
        rx_idle = 48;
        hold_asked = 0;
        sb = new(URG_DEPTH, NRM_DEPTH);
        sb.reload(16'd1);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // ordering, ties at equal score, both queues, unused opcode
        send_word(make_word(OP_URGENT_ACQ, 8'h00, 16'h0000, 16'h0000));
        send_word(make_word(OP_URGENT_ACQ, 8'hFF, 16'hFFFF, 16'hFFFF));
        send_word(make_word(OP_URGENT_ACQ, 8'h01, 16'h0000, 16'h0000));
        send_word(make_word(OP_URGENT_ACQ, 8'hA5, 16'h0005, 16'h0003));
        send_word(make_word(OP_URGENT_ACQ, 8'h5A, 16'h0003, 16'h0005));
        send_word(make_word(OP_NORMAL_ACQ, 8'h11, 16'hFFFF, 16'hFFFF));
        send_word(make_word(OP_NORMAL_ACQ, 8'hEE, 16'h0000, 16'h0000));
        send_word(make_word(OP_UNUSED, 8'hC3, 16'hAAAA, 16'h5555));
        repeat (7) send_word(make_word(OP_RELEASE, 8'h00, 16'h0000, 16'h0000));
        send_word(make_word(OP_NORMAL_ACQ, 8'h7E, 16'h1234, 16'h4321));

        // count at its maximum
        drain();
        write_count('1);
        send_word(make_word(OP_RELEASE, 8'h00, 16'h0000, 16'h0000));
        send_word(make_word(OP_URGENT_ACQ, 8'h81, 16'h8000, 16'h8000));
        send_word(make_word(OP_RELEASE, 8'hFF, 16'hFFFF, 16'hFFFF));
        send_word(make_word(OP_RELEASE, 8'h00, 16'h0000, 16'h0000));

        drain();
        write_count('0);
        send_word(make_word(OP_RELEASE, 8'h3C, 16'h0000, 16'h0000));
        send_word(make_word(OP_NORMAL_ACQ, 8'hC3, 16'h0000, 16'h0000));

        run_phase(13, 48, 1'b0);
        run_phase(48, 13, 1'b0);
        run_phase(0, 0, 1'b1);

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
